### hdl/hsvc_pkg.sv
package hsvc_pkg;

  // one input transaction
  typedef struct packed {
    logic [8:0] hue_degrees;
    logic [6:0] saturation_pct;
    logic [7:0] bright_level;
  } in_item_t;

  // one result transaction
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // hue sectors, NONE is a hue past the full circle
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5,
    SEC_NONE    = 3'd6
  } sector_t;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned QUOT_W = CHAN_W;

  localparam logic [7:0]  FULL_LEVEL_RST = 8'd100;
  localparam logic [7:0]  FULL_SCALE     = 8'd255;
  localparam logic [8:0]  HUE_SECTOR_DEG = 9'd60;
  localparam logic [8:0]  HUE_WRAP_DEG   = 9'd360;

  // sat * 255 / 100 as one multiply by ceil(2^19 * 255 / 100), exact over 0..127
  localparam logic [20:0] SAT_RECIP  = 21'd1336935;
  localparam int unsigned SAT_SHIFT  = 19;
  // x / 60 as multiply by ceil(2^20 / 60), exact for x below 2^14
  localparam logic [14:0] RAMP_RECIP = 15'd17477;
  localparam int unsigned RAMP_SHIFT = 20;

  // accept edge to the edge that takes the result
  localparam int unsigned PIPE_LATENCY = 8;

endpackage

### hdl/hsv_to_rgb_converter.sv
// hsv to rgb converter, integer six-sector scheme
// input: a transaction is taken at each rising edge with start high and busy
//   low; busy is always low, so one pixel can enter every clock
// in_data carries hue in degrees, saturation in percent and a brightness level
// config: cfg_wr_en/cfg_wr_data write full_level, the level that maps to 255;
//   write it only while no transaction is in flight
// output: out_strobe marks out_data for exactly one cycle, PIPE_LATENCY (8)
//   clock edges after the accepting edge; one result per input, in order
// throughput: one transaction per clock; the latency is set by the two-stage
//   restoring divider for the brightness scale and by three multiplies in
//   series (low level, ramp product, divide by sixty)
// reset: rst_n low at a clock edge empties the pipeline and sets full_level
//   to 100; transactions in flight are dropped
// the receiver cannot stall, so nothing in the pipeline ever waits
module hsv_to_rgb_converter (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hsvc_pkg::in_item_t   in_data,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  output logic                 out_strobe,
  output hsvc_pkg::out_item_t  out_data
);
  import hsvc_pkg::*;

  typedef struct packed {
    sector_t    sec;
    logic [5:0] hue_off;
    logic [7:0] sat;
    logic       grey;
    logic       vsat;
  } side_t;

  localparam int unsigned STAGES = 8;

  logic [7:0]            full_level_r;
  logic [STAGES-1:0]     vld_r;
  logic [STAGES-1:0]     vld_nxt;

  side_t                 side_nxt;
  side_t                 side1_r, side2_r, side3_r, side4_r, side5_r, side6_r, side7_r;
  logic [15:0]           dividend_nxt;
  logic [15:0]           dividend1_r;
  logic [7:0]            divisor_nxt;
  logic [7:0]            divisor1_r;
  logic [7:0]            quot;

  logic [7:0]            hi_nxt;
  logic [7:0]            hi4_r, hi5_r, hi6_r, hi7_r;
  logic [15:0]           lo_prod4_r;
  logic [16:0]           lo_sum;
  logic [7:0]            lo_nxt;
  logic [7:0]            lo5_r, lo6_r, lo7_r;
  logic [7:0]            diff5_r;
  logic [13:0]           ramp_prod6_r;
  logic [28:0]           ramp_full;
  logic [7:0]            ramp7_r;

  out_item_t             out_nxt;
  out_item_t             out_r;
  side_t                 side8_r;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_level_r <= FULL_LEVEL_RST;
    end else if (cfg_wr_en) begin
      full_level_r <= cfg_wr_data;
    end
  end

  // valid bits travel with the data
  assign vld_nxt = {vld_r[STAGES-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // stage 1: hue sector, saturation scale, brightness dividend
  always_comb begin
    logic [8:0]  h;
    logic [8:0]  base;
    logic [27:0] sat_prod;
    logic [8:0]  sat_raw;
    h = in_data.hue_degrees;
    if (h < HUE_SECTOR_DEG) begin
      side_nxt.sec = SEC_RED;     base = 9'd0;
    end else if (h < 9'(2 * HUE_SECTOR_DEG)) begin
      side_nxt.sec = SEC_YELLOW;  base = HUE_SECTOR_DEG;
    end else if (h < 9'(3 * HUE_SECTOR_DEG)) begin
      side_nxt.sec = SEC_GREEN;   base = 9'(2 * HUE_SECTOR_DEG);
    end else if (h < 9'(4 * HUE_SECTOR_DEG)) begin
      side_nxt.sec = SEC_CYAN;    base = 9'(3 * HUE_SECTOR_DEG);
    end else if (h < 9'(5 * HUE_SECTOR_DEG)) begin
      side_nxt.sec = SEC_BLUE;    base = 9'(4 * HUE_SECTOR_DEG);
    end else if (h < HUE_WRAP_DEG) begin
      side_nxt.sec = SEC_MAGENTA; base = 9'(5 * HUE_SECTOR_DEG);
    end else if (h == HUE_WRAP_DEG) begin
      side_nxt.sec = SEC_RED;     base = HUE_WRAP_DEG;
    end else begin
      side_nxt.sec = SEC_NONE;    base = h;
    end
    side_nxt.hue_off = 6'(h - base);

    sat_prod      = 28'(in_data.saturation_pct) * 28'(SAT_RECIP);
    sat_raw       = sat_prod[SAT_SHIFT +: 9];
    side_nxt.sat  = (sat_raw > {1'b0, FULL_SCALE}) ? FULL_SCALE : sat_raw[7:0];
    side_nxt.grey = (in_data.saturation_pct == 7'd0);

    // level * 255, full_level of zero divides as one
    dividend_nxt  = {in_data.bright_level, 8'd0} - 16'(in_data.bright_level);
    divisor_nxt   = (full_level_r == 8'd0) ? 8'd1 : full_level_r;
    side_nxt.vsat = (dividend_nxt[15:8] >= divisor_nxt);
  end

  always_ff @(posedge clk) begin
    side1_r     <= side_nxt;
    dividend1_r <= dividend_nxt;
    divisor1_r  <= divisor_nxt;
  end

  // stages 2 and 3: brightness divide
  hsvc_div u_div (
    .clk         (clk),
    .dividend_in (dividend1_r),
    .divisor_in  (divisor1_r),
    .quot_out    (quot)
  );

  always_ff @(posedge clk) begin
    side2_r <= side1_r;
    side3_r <= side2_r;
  end

  // stage 4: value and low-level product
  assign hi_nxt = side3_r.vsat ? FULL_SCALE : quot;

  always_ff @(posedge clk) begin
    side4_r    <= side3_r;
    hi4_r      <= hi_nxt;
    lo_prod4_r <= 16'(FULL_SCALE - side3_r.sat) * 16'(hi_nxt);
  end

  // stage 5: divide by 255 and ramp span
  assign lo_sum = 17'(lo_prod4_r) + 17'(lo_prod4_r[15:8]) + 17'd1;
  assign lo_nxt = lo_sum[15:8];

  always_ff @(posedge clk) begin
    side5_r <= side4_r;
    hi5_r   <= hi4_r;
    lo5_r   <= lo_nxt;
    diff5_r <= hi4_r - lo_nxt;
  end

  // stage 6: ramp product
  always_ff @(posedge clk) begin
    side6_r      <= side5_r;
    hi6_r        <= hi5_r;
    lo6_r        <= lo5_r;
    ramp_prod6_r <= 14'(diff5_r) * 14'(side5_r.hue_off);
  end

  // stage 7: divide by sixty
  assign ramp_full = 29'(ramp_prod6_r) * 29'(RAMP_RECIP);

  always_ff @(posedge clk) begin
    side7_r <= side6_r;
    hi7_r   <= hi6_r;
    lo7_r   <= lo6_r;
    ramp7_r <= ramp_full[RAMP_SHIFT +: 8];
  end

  // stage 8: sector select
  always_comb begin
    logic [7:0] up;
    logic [7:0] down;
    up   = lo7_r + ramp7_r;
    down = hi7_r - ramp7_r;
    if (side7_r.grey) begin
      out_nxt = '{red: hi7_r, green: hi7_r, blue: hi7_r};
    end else begin
      case (side7_r.sec)
        SEC_RED:     out_nxt = '{red: hi7_r, green: up,    blue: lo7_r};
        SEC_YELLOW:  out_nxt = '{red: down,  green: hi7_r, blue: lo7_r};
        SEC_GREEN:   out_nxt = '{red: lo7_r, green: hi7_r, blue: up};
        SEC_CYAN:    out_nxt = '{red: lo7_r, green: down,  blue: hi7_r};
        SEC_BLUE:    out_nxt = '{red: up,    green: lo7_r, blue: hi7_r};
        SEC_MAGENTA: out_nxt = '{red: hi7_r, green: lo7_r, blue: down};
        default:     out_nxt = '{red: 8'd0,  green: 8'd0,  blue: 8'd0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    side8_r <= side7_r;
  end

  assign busy       = 1'b0;
  assign out_strobe = vld_r[STAGES-1];
  assign out_data   = out_r;

  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_strobe)
    else $error("accepted transaction did not produce a result");

  // no result without an accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result strobe without a matching transaction");

  // zero saturation always gives grey
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && side8_r.grey) |->
      (out_data.red == out_data.green && out_data.green == out_data.blue))
    else $error("zero saturation result is not grey");

endmodule

### hdl/hsvc_div.sv
module hsvc_div (
  input  logic                          clk,
  input  logic [2*hsvc_pkg::QUOT_W-1:0] dividend_in,
  input  logic [hsvc_pkg::QUOT_W-1:0]   divisor_in,
  output logic [hsvc_pkg::QUOT_W-1:0]   quot_out
);
  import hsvc_pkg::*;

  localparam int unsigned HALF = QUOT_W / 2;

  logic [QUOT_W-1:0] rem_a_nxt;
  logic [HALF-1:0]   q_hi_nxt;
  logic [QUOT_W-1:0] rem_a_r;
  logic [HALF-1:0]   q_hi_r;
  logic [HALF-1:0]   low_bits_r;
  logic [QUOT_W-1:0] divisor_r;
  logic [HALF-1:0]   q_lo_nxt;
  logic [QUOT_W-1:0] quot_r;

  // upper quotient bits, restoring steps, remainder starts at the top byte
  always_comb begin
    logic [QUOT_W:0]   trial;
    logic [QUOT_W-1:0] rem;
    rem      = dividend_in[2*QUOT_W-1:QUOT_W];
    q_hi_nxt = '0;
    for (int i = HALF - 1; i >= 0; i--) begin
      trial = {rem, dividend_in[HALF + i]};
      if (trial >= {1'b0, divisor_in}) begin
        rem         = QUOT_W'(trial - {1'b0, divisor_in});
        q_hi_nxt[i] = 1'b1;
      end else begin
        rem = trial[QUOT_W-1:0];
      end
    end
    rem_a_nxt = rem;
  end

  always_ff @(posedge clk) begin
    rem_a_r    <= rem_a_nxt;
    q_hi_r     <= q_hi_nxt;
    low_bits_r <= dividend_in[HALF-1:0];
    divisor_r  <= divisor_in;
  end

  // lower quotient bits
  always_comb begin
    logic [QUOT_W:0]   trial;
    logic [QUOT_W-1:0] rem;
    rem      = rem_a_r;
    q_lo_nxt = '0;
    for (int i = HALF - 1; i >= 0; i--) begin
      trial = {rem, low_bits_r[i]};
      if (trial >= {1'b0, divisor_r}) begin
        rem         = QUOT_W'(trial - {1'b0, divisor_r});
        q_lo_nxt[i] = 1'b1;
      end else begin
        rem = trial[QUOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= {q_hi_r, q_lo_nxt};
  end

  assign quot_out = quot_r;

endmodule
